### sv/jtsv_pkg.sv
package jtsv_pkg;

   localparam int MAX_DEPTH = 32;
   localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   localparam logic [3:0] TK_LBRACE   = 4'd0;
   localparam logic [3:0] TK_RBRACE   = 4'd1;
   localparam logic [3:0] TK_LBRACKET = 4'd2;
   localparam logic [3:0] TK_RBRACKET = 4'd3;
   localparam logic [3:0] TK_COLON    = 4'd4;
   localparam logic [3:0] TK_COMMA    = 4'd5;
   localparam logic [3:0] TK_STRING   = 4'd6;
   localparam logic [3:0] TK_NUMBER   = 4'd7;
   localparam logic [3:0] TK_TRUE     = 4'd8;
   localparam logic [3:0] TK_FALSE    = 4'd9;
   localparam logic [3:0] TK_NULL     = 4'd10;

   localparam logic [3:0] PS_START     = 4'd0;
   localparam logic [3:0] PS_OBJ_START = 4'd1;
   localparam logic [3:0] PS_OBJ_KEY   = 4'd2;
   localparam logic [3:0] PS_OBJ_COLON = 4'd3;
   localparam logic [3:0] PS_OBJ_VALUE = 4'd4;
   localparam logic [3:0] PS_OBJ_COMMA = 4'd5;
   localparam logic [3:0] PS_ARR_START = 4'd6;
   localparam logic [3:0] PS_ARR_VALUE = 4'd7;
   localparam logic [3:0] PS_ARR_COMMA = 4'd8;
   localparam logic [3:0] PS_DONE      = 4'd9;

   localparam logic RET_OBJECT = 1'b0;
   localparam logic RET_ARRAY  = 1'b1;

   localparam logic [1:0] ST_VALID    = 2'd0;
   localparam logic [1:0] ST_ACCEPTED = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   typedef struct packed {
      logic [3:0] token_kind;
      logic       last_token;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] depth;
   } rsp_payload_type;

endpackage

### sv/jtsv_ram.sv
module jtsv_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/json_token_structure_validator.sv
// JSON token structure validator. Takes one token kind per cycle and returns one
// result per token (status and open-container depth) through a registered output
// stage, in the cycle after the token is accepted; a new token is taken in every cycle
// that the output register is empty or being drained. The nesting stack is a
// 1-bit x MAX_DEPTH single-port-write RAM with registered read: the top entry is
// held in a register and the entry below it is read ahead every cycle, so a close
// bracket pops without a stall and back-to-back pushes and pops need none either. An
// error holds status at rejected until the token flagged last, which reports the
// document outcome and re-arms the parser; no clearing pass is needed after reset.
module json_token_structure_validator
   import jtsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic [3:0]         state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               err_ff, err_in;
   logic               first_ff, first_in;
   logic               top_ff, top_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               below_kind;
   logic [3:0]         tok;
   logic               last;
   logic               scalar;
   logic               ok;
   logic               do_open, do_close;
   logic               open_ret;
   logic [3:0]         nstate;
   logic [LEVEL_W-1:0] nlevel;
   logic               push, pop;
   logic               step_ok;
   logic [LEVEL_W-1:0] rd_level;

   assign tok       = req_data.token_kind;
   assign last      = req_data.last_token;
   assign scalar    = (tok inside {[TK_STRING:TK_NULL]});
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      nstate   = state_ff;
      nlevel   = level_ff;
      ok       = 1'b0;
      do_open  = 1'b0;
      do_close = 1'b0;
      open_ret = RET_OBJECT;
      push     = 1'b0;
      pop      = 1'b0;

      case (state_ff)
         PS_START: begin
            if (tok == TK_LBRACE || tok == TK_LBRACKET) begin
               do_open = 1'b1;
            end else if (scalar && first_ff && last) begin
               nstate = PS_DONE;
               ok     = 1'b1;
            end
         end
         PS_OBJ_START: begin
            if (tok == TK_RBRACE) begin
               do_close = 1'b1;
            end else if (tok == TK_STRING) begin
               nstate = PS_OBJ_KEY;
               ok     = 1'b1;
            end
         end
         PS_OBJ_KEY: begin
            if (tok == TK_COLON) begin
               nstate = PS_OBJ_COLON;
               ok     = 1'b1;
            end
         end
         PS_OBJ_COLON: begin
            if (tok == TK_LBRACE || tok == TK_LBRACKET) begin
               do_open = 1'b1;
            end else if (scalar) begin
               nstate = PS_OBJ_VALUE;
               ok     = 1'b1;
            end
         end
         PS_OBJ_VALUE: begin
            if (tok == TK_RBRACE) begin
               do_close = 1'b1;
            end else if (tok == TK_COMMA) begin
               nstate = PS_OBJ_COMMA;
               ok     = 1'b1;
            end
         end
         PS_OBJ_COMMA: begin
            if (tok == TK_STRING) begin
               nstate = PS_OBJ_KEY;
               ok     = 1'b1;
            end
         end
         PS_ARR_START, PS_ARR_VALUE, PS_ARR_COMMA: begin
            if (tok == TK_RBRACKET && state_ff != PS_ARR_COMMA) begin
               do_close = 1'b1;
            end else if (tok == TK_COMMA && state_ff == PS_ARR_VALUE) begin
               nstate = PS_ARR_COMMA;
               ok     = 1'b1;
            end else if (state_ff != PS_ARR_VALUE) begin
               open_ret = RET_ARRAY;
               if (tok == TK_LBRACE || tok == TK_LBRACKET) begin
                  do_open = 1'b1;
               end else if (scalar) begin
                  nstate = PS_ARR_VALUE;
                  ok     = 1'b1;
               end
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (do_open && (LEVEL_W'(MAX_DEPTH) > level_ff)) begin
         push   = 1'b1;
         ok     = 1'b1;
         nlevel = level_ff + 1'b1;
         nstate = (tok == TK_LBRACE) ? PS_OBJ_START : PS_ARR_START;
      end

      if (do_close && level_ff != '0) begin
         pop    = 1'b1;
         ok     = 1'b1;
         nlevel = level_ff - 1'b1;
         if (level_ff == LEVEL_W'(1)) begin
            nstate = PS_DONE;
         end else begin
            nstate = top_ff ? PS_ARR_VALUE : PS_OBJ_VALUE;
         end
      end
   end

   assign step_ok = accept && !err_ff && ok;

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      err_in       = err_ff;
      first_in     = first_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         first_in = 1'b0;
         if (step_ok) begin
            state_in = nstate;
            level_in = nlevel;
            if (push) begin
               top_in = open_ret;
            end else if (pop) begin
               top_in = below_kind;
            end
         end else begin
            err_in = 1'b1;
         end

         rsp_valid_in      = 1'b1;
         rsp_data_in.depth = 6'(level_in);
         if (last) begin
            rsp_data_in.status = (!err_in && state_in == PS_DONE) ? ST_ACCEPTED : ST_REJECTED;
            state_in = PS_START;
            level_in = '0;
            err_in   = 1'b0;
            first_in = 1'b1;
         end else begin
            rsp_data_in.status = err_in ? ST_REJECTED : ST_VALID;
         end
      end
   end

   // Prefetch the entry below the next top of stack.
   assign rd_level = level_in - LEVEL_W'(2);

   jtsv_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (step_ok && push),
      .wr_addr (level_ff[ADDR_W-1:0]),
      .wr_data (open_ret),
      .rd_addr (rd_level[ADDR_W-1:0]),
      .rd_data (below_kind)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PS_START;
         level_ff     <= '0;
         err_ff       <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         err_ff       <= err_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/jtsv_checker.sv
module jtsv_checker
   import jtsv_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // Hold a stalled result transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Every accepted token yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted token gave no result");

   // A full output stage that is not drained blocks input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stage full");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == ST_VALID || rsp_data.status == ST_ACCEPTED
                    || rsp_data.status == ST_REJECTED)
      else $error("bad status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_DEPTH > 63) || (int'(rsp_data.depth) <= MAX_DEPTH))
      else $error("depth beyond limit");

endmodule

bind json_token_structure_validator jtsv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
